// ----- rtl/core/fdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Floppy disk controller core - shared definitions
// Field widths, register and command codes, status bits and the transaction
// types that pass between the controller, its offset unit and the ports.
// ----------------------------------------------------------------------------
package fdc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SECTOR_BYTES   = 1024;
    localparam int DEF_INDEX_TOGGLE_READS = 64;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int TRACK_W   = 8;
    localparam int SECTOR_W  = 8;
    localparam int SPT_W     = 7;
    localparam int SS_W      = 11;
    localparam int TC_W      = 8;
    localparam int OFFSET_W  = 24;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    // Offset accumulator: (track * spt + rem) stays below 2^15, times 11 bits
    localparam int ACC_W = TRACK_W + SPT_W + SS_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_T = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_PRESENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SELECT  = 3'd4;

    // Configuration reset values
    localparam logic [SS_W-1:0]  RST_SECTOR_SIZE = 11'd512;
    localparam logic [SPT_W-1:0] RST_SPT         = 7'd10;
    localparam logic [TC_W-1:0]  RST_TRACK_COUNT = 8'd40;

    // Bus register selects
    localparam logic [1:0] REG_CMD    = 2'd0;
    localparam logic [1:0] REG_TRACK  = 2'd1;
    localparam logic [1:0] REG_SECTOR = 2'd2;
    localparam logic [1:0] REG_DATA   = 2'd3;

    // Transaction kinds
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_BYTE  = 2'd2,
        OP_FAIL  = 2'd3
    } t_op;

    // Command decode masks and codes
    localparam logic [BYTE_W-1:0] CMD_TYPE_MASK   = 8'hf0;
    localparam logic [BYTE_W-1:0] CMD_READ_MASK   = 8'he0;
    localparam logic [BYTE_W-1:0] CMD_RESTORE     = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_SEEK        = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_READ_SECTOR = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_READ_ADDR   = 8'hc0;
    localparam logic [BYTE_W-1:0] CMD_FORCE_INT   = 8'hd0;

    // Status bits
    localparam logic [BYTE_W-1:0] ST_NOT_READY = 8'h80;
    localparam logic [BYTE_W-1:0] ST_TRACK0    = 8'h04;
    localparam logic [BYTE_W-1:0] ST_INDEX     = 8'h02;
    localparam logic [BYTE_W-1:0] ST_DRQ       = 8'h02;
    localparam logic [BYTE_W-1:0] ST_BUSY      = 8'h01;

    // Fill byte for blank sectors and the Read Address ID field
    localparam logic [BYTE_W-1:0] BLANK_BYTE   = 8'he5;
    localparam logic [BYTE_W-1:0] ID_SIZE_CODE = 8'h02;
    localparam int                ID_BYTES     = 6;

    // Input transaction
    typedef struct packed {
        t_op                 op;
        logic [1:0]          reg_select;
        logic [BYTE_W-1:0]   write_value;
        logic [BYTE_W-1:0]   disk_byte;
    } t_fdc_in;

    // Result transaction
    typedef struct packed {
        logic [BYTE_W-1:0]   read_value;
        logic                interrupt_line;
        logic                data_request;
        logic                fetch_start;
        logic [OFFSET_W-1:0] fetch_offset;
    } t_fdc_out;

    // Offset unit request and response
    typedef struct packed {
        logic                start;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [SPT_W-1:0]    spt;
        logic [SS_W-1:0]     sector_size;
    } t_off_req;

    typedef struct packed {
        logic                done;
        logic [OFFSET_W-1:0] offset;
    } t_off_rsp;

endpackage

// ----- rtl/core/fdc_offset_unit.sv -----
// ----------------------------------------------------------------------------
// Sector offset unit
// Computes (track * spt + sector mod spt) * sector_size on one shared
// add/subtract unit: restoring remainder, then two shift-add multiplies.
// ----------------------------------------------------------------------------
module fdc_offset_unit
    import fdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_off_req i_req,
    output t_off_rsp o_rsp
);

    localparam int STEP_W = $clog2(SS_W);

    typedef enum logic [1:0] {
        U_IDLE,
        U_MOD,
        U_MUL1,
        U_MUL2
    } t_ustate;

    t_ustate             r_state,  n_state;
    logic [STEP_W-1:0]   r_step,   n_step;
    logic [SECTOR_W-1:0] r_rem,    n_rem;
    logic [SECTOR_W-1:0] r_div,    n_div;
    logic [SPT_W-1:0]    r_spt,    n_spt;
    logic [SS_W-1:0]     r_ss,     n_ss;
    logic [ACC_W-1:0]    r_acc,    n_acc;
    logic [ACC_W-1:0]    r_mcand,  n_mcand;
    logic [SS_W-1:0]     r_mplier, n_mplier;
    logic                r_done,   n_done;

    // Shared add/subtract unit; carry out on subtract means a >= b
    logic [ACC_W-1:0]    alu_a;
    logic [ACC_W-1:0]    alu_b;
    logic                alu_sub;
    logic [ACC_W:0]      alu_sum;
    logic [SECTOR_W-1:0] rem_shift;

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {ACC_W{alu_sub}}}
                   + (ACC_W+1)'(alu_sub);

    // Sequence the remainder and multiply steps
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_rem     = r_rem;
        n_div     = r_div;
        n_spt     = r_spt;
        n_ss      = r_ss;
        n_acc     = r_acc;
        n_mcand   = r_mcand;
        n_mplier  = r_mplier;
        n_done    = 1'b0;
        alu_a     = r_acc;
        alu_b     = '0;
        alu_sub   = 1'b0;
        rem_shift = {r_rem[SECTOR_W-2:0], r_div[SECTOR_W-1]};

        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_mcand = ACC_W'(i_req.track);
                    n_div   = i_req.sector;
                    n_rem   = '0;
                    n_spt   = i_req.spt;
                    n_ss    = i_req.sector_size;
                    n_step  = '0;
                    n_state = U_MOD;
                end
            end
            U_MOD: begin
                alu_a   = ACC_W'(rem_shift);
                alu_b   = ACC_W'(r_spt);
                alu_sub = 1'b1;
                n_rem   = alu_sum[ACC_W] ? alu_sum[SECTOR_W-1:0] : rem_shift;
                n_div   = r_div << 1;
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SECTOR_W - 1)) begin
                    // no wrap without sectors: offset within track is zero
                    n_acc    = (r_spt == '0) ? '0 : ACC_W'(n_rem);
                    n_mplier = SS_W'(r_spt);
                    n_step   = '0;
                    n_state  = U_MUL1;
                end
            end
            U_MUL1: begin
                alu_b    = r_mplier[0] ? r_mcand : '0;
                n_acc    = alu_sum[ACC_W-1:0];
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_step   = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SPT_W - 1)) begin
                    n_mcand  = alu_sum[ACC_W-1:0];
                    n_acc    = '0;
                    n_mplier = r_ss;
                    n_step   = '0;
                    n_state  = U_MUL2;
                end
            end
            U_MUL2: begin
                alu_b    = r_mplier[0] ? r_mcand : '0;
                n_acc    = alu_sum[ACC_W-1:0];
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_step   = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SS_W - 1)) begin
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    // Hold state and datapath registers
    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_spt    <= n_spt;
        r_ss     <= n_ss;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.offset = r_acc[OFFSET_W-1:0];

endmodule

// ----- rtl/core/fdc_sector_buf.sv -----
// ----------------------------------------------------------------------------
// Sector buffer
// Single write port, single read port byte memory with registered read data.
// ----------------------------------------------------------------------------
module fdc_sector_buf
    import fdc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_SECTOR_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [BYTE_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [BYTE_W-1:0]        o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Write on enable, register the read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/floppy_disk_controller_core_unit.sv -----
// ----------------------------------------------------------------------------
// Floppy disk controller core
// Command/status, track, sector and data registers with a sector buffer
// filled from an external backing store.
// ----------------------------------------------------------------------------
// Use: a transaction (bus read, bus write, store byte or store failure) is
// taken on i_req when start is high and busy is low. Its single result shows
// on o_result for one cycle with o_done; the receiver cannot hold it off.
// Register access, store byte or failure and most commands finish in the
// execute state; a data register read from the sector buffer waits for the
// registered memory read; Read Address makes one buffer write per ID byte;
// Read Sector with a fetch waits for the offset unit: 8 remainder steps,
// 7 + 11 shift-add steps on one shared adder.
// A new transaction may be started in the cycle that o_done is high.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at
// the clock edge; the user must make them while the core is idle, and the
// core does not enforce this. Reset (i_rst_n low, synchronous) clears the
// controller registers and flags and restores the configuration defaults;
// the held request and result and the buffer contents are left as is.
// ----------------------------------------------------------------------------
module floppy_disk_controller_core_unit
    import fdc_pkg::*;
#(
    parameter int MAX_SECTOR_BYTES   = DEF_MAX_SECTOR_BYTES,
    parameter int INDEX_TOGGLE_READS = DEF_INDEX_TOGGLE_READS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_fdc_in              i_req,
    output logic                 busy,
    output logic                 o_done,
    output t_fdc_out             o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int AW = $clog2(MAX_SECTOR_BYTES);
    localparam int LW = $clog2(MAX_SECTOR_BYTES + 1);
    localparam int IW = $clog2(INDEX_TOGGLE_READS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_IDWRITE,
        S_OFFSET
    } t_state;

    // Configuration
    logic [SS_W-1:0]   r_cfg_ss;
    logic [SPT_W-1:0]  r_cfg_spt;
    logic [TC_W-1:0]   r_cfg_tc;
    logic              r_cfg_img;
    logic              r_cfg_sel;

    // Controller state
    t_state            r_state,   n_state;
    t_fdc_in           r_item,    n_item;
    logic [BYTE_W-1:0] r_status,  n_status;
    logic [BYTE_W-1:0] r_command, n_command;
    logic [BYTE_W-1:0] r_track,   n_track;
    logic [BYTE_W-1:0] r_sector,  n_sector;
    logic [BYTE_W-1:0] r_data,    n_data;
    logic              r_drq,     n_drq;
    logic              r_intrq,   n_intrq;
    logic              r_ipulse,  n_ipulse;
    logic [IW-1:0]     r_icnt,    n_icnt;
    logic [LW-1:0]     r_rptr,    n_rptr;
    logic [LW-1:0]     r_tl,      n_tl;
    logic [LW-1:0]     r_fptr,    n_fptr;
    logic              r_fill,    n_fill;
    logic              r_blank,   n_blank;
    logic [2:0]        r_idcnt,   n_idcnt;
    logic              r_done,    n_done;
    t_fdc_out          r_result,  n_result;

    // Buffer and offset unit connections
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;
    t_off_req          off_req;
    t_off_rsp          off_rsp;

    fdc_sector_buf #(
        .DEPTH (MAX_SECTOR_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rptr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    fdc_offset_unit u_off (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (off_req),
        .o_rsp   (off_rsp)
    );

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ss  <= RST_SECTOR_SIZE;
            r_cfg_spt <= RST_SPT;
            r_cfg_tc  <= RST_TRACK_COUNT;
            r_cfg_img <= 1'b0;
            r_cfg_sel <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SECTOR_SIZE:   r_cfg_ss  <= i_cfg_wdata[SS_W-1:0];
                CFG_SECTORS_PER_T: r_cfg_spt <= i_cfg_wdata[SPT_W-1:0];
                CFG_TRACK_COUNT:   r_cfg_tc  <= i_cfg_wdata[TC_W-1:0];
                CFG_IMAGE_PRESENT: r_cfg_img <= i_cfg_wdata[0];
                CFG_DRIVE_SELECT:  r_cfg_sel <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Decode and execute one transaction
    always_comb begin
        logic [BYTE_W-1:0]   cmd;
        logic [BYTE_W-1:0]   rv;
        logic                fin;
        logic                fstart;
        logic [OFFSET_W-1:0] foff;
        logic [IW:0]         icnt_inc;
        logic [LW-1:0]       rptr_inc;
        logic [LW-1:0]       fptr_inc;
        logic [LW-1:0]       cap;

        n_state   = r_state;
        n_item    = r_item;
        n_status  = r_status;
        n_command = r_command;
        n_track   = r_track;
        n_sector  = r_sector;
        n_data    = r_data;
        n_drq     = r_drq;
        n_intrq   = r_intrq;
        n_ipulse  = r_ipulse;
        n_icnt    = r_icnt;
        n_rptr    = r_rptr;
        n_tl      = r_tl;
        n_fptr    = r_fptr;
        n_fill    = r_fill;
        n_blank   = r_blank;
        n_idcnt   = r_idcnt;
        n_done    = 1'b0;
        n_result  = r_result;

        mem_we    = 1'b0;
        mem_waddr = r_fptr[AW-1:0];
        mem_wdata = r_item.disk_byte;

        off_req.start       = 1'b0;
        off_req.track       = r_track;
        off_req.sector      = r_sector;
        off_req.spt         = r_cfg_spt;
        off_req.sector_size = r_cfg_ss;

        cmd      = r_item.write_value;
        rv       = '0;
        fin      = 1'b0;
        fstart   = 1'b0;
        foff     = '0;
        icnt_inc = (IW+1)'(r_icnt) + (IW+1)'(1);
        rptr_inc = r_rptr + LW'(1);
        fptr_inc = r_fptr + LW'(1);
        cap      = (32'(r_cfg_ss) > MAX_SECTOR_BYTES) ? LW'(MAX_SECTOR_BYTES)
                                                      : LW'(r_cfg_ss);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_req;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_item.op)
                    OP_READ: begin
                        case (r_item.reg_select)
                            REG_CMD: begin
                                // build status; after a Type I command, advance the index pulse
                                rv = r_status;
                                if (!r_cfg_img || !r_cfg_sel) begin
                                    rv = rv | ST_NOT_READY;
                                end
                                if (!r_command[7]) begin
                                    if (r_track == '0) begin
                                        rv = rv | ST_TRACK0;
                                    end
                                    if (icnt_inc > (IW+1)'(INDEX_TOGGLE_READS)) begin
                                        n_ipulse = !r_ipulse;
                                        n_icnt   = '0;
                                    end else begin
                                        n_icnt = icnt_inc[IW-1:0];
                                    end
                                    if (n_ipulse) begin
                                        rv = rv | ST_INDEX;
                                    end
                                end else if (r_drq) begin
                                    rv = rv | ST_DRQ;
                                end
                                n_intrq = 1'b0;
                                fin     = 1'b1;
                            end
                            REG_TRACK: begin
                                rv  = r_track;
                                fin = 1'b1;
                            end
                            REG_SECTOR: begin
                                rv  = r_sector;
                                fin = 1'b1;
                            end
                            default: begin
                                // drain the buffer while a transfer is open
                                if (r_drq && (r_rptr < r_tl)) begin
                                    n_rptr = rptr_inc;
                                    if (rptr_inc >= r_tl) begin
                                        n_drq    = 1'b0;
                                        n_intrq  = 1'b1;
                                        n_status = '0;
                                    end
                                    n_state = S_RDATA;
                                end else begin
                                    rv  = r_data;
                                    fin = 1'b1;
                                end
                            end
                        endcase
                    end

                    OP_WRITE: begin
                        case (r_item.reg_select)
                            REG_CMD: begin
                                n_command = cmd;
                                n_fill    = 1'b0;
                                if (!cmd[7]) begin
                                    // Type I: restore, seek, others
                                    if ((cmd & CMD_TYPE_MASK) == CMD_RESTORE) begin
                                        n_track  = '0;
                                        n_status = ST_TRACK0;
                                    end else if ((cmd & CMD_TYPE_MASK) == CMD_SEEK) begin
                                        n_track  = r_data;
                                        n_status = '0;
                                    end
                                    n_intrq = 1'b1;
                                    fin     = 1'b1;
                                end else if ((cmd & CMD_READ_MASK) == CMD_READ_SECTOR) begin
                                    n_status = ST_BUSY;
                                    n_intrq  = 1'b0;
                                    n_rptr   = '0;
                                    n_tl     = cap;
                                    if (r_cfg_img && (r_track < r_cfg_tc)) begin
                                        n_blank = 1'b0;
                                        n_fptr  = '0;
                                        if (cap == '0) begin
                                            n_drq = 1'b1;
                                        end else begin
                                            n_fill = 1'b1;
                                            n_drq  = 1'b0;
                                        end
                                        off_req.start = 1'b1;
                                        n_state       = S_OFFSET;
                                    end else begin
                                        n_blank = 1'b1;
                                        n_drq   = 1'b1;
                                        fin     = 1'b1;
                                    end
                                end else if ((cmd & CMD_TYPE_MASK) == CMD_READ_ADDR) begin
                                    n_status = ST_BUSY;
                                    n_intrq  = 1'b0;
                                    n_rptr   = '0;
                                    n_tl     = LW'(ID_BYTES);
                                    n_blank  = 1'b0;
                                    n_drq    = 1'b1;
                                    n_idcnt  = '0;
                                    n_state  = S_IDWRITE;
                                end else if ((cmd & CMD_TYPE_MASK) == CMD_FORCE_INT) begin
                                    n_status = '0;
                                    n_intrq  = (cmd[3:0] != 4'd0);
                                    fin      = 1'b1;
                                end else begin
                                    n_status = '0;
                                    n_intrq  = 1'b1;
                                    fin      = 1'b1;
                                end
                            end
                            REG_TRACK: begin
                                n_track = cmd;
                                fin     = 1'b1;
                            end
                            REG_SECTOR: begin
                                n_sector = cmd;
                                fin      = 1'b1;
                            end
                            default: begin
                                n_data = cmd;
                                fin    = 1'b1;
                            end
                        endcase
                    end

                    OP_BYTE: begin
                        // store the byte, raise DRQ once the sector is in
                        if (r_fill) begin
                            mem_we = 1'b1;
                            n_fptr = fptr_inc;
                            if (fptr_inc >= r_tl) begin
                                n_fill = 1'b0;
                                n_drq  = 1'b1;
                            end
                        end
                        fin = 1'b1;
                    end

                    default: begin
                        // fetch failed: blank the sector
                        if (r_fill) begin
                            n_fill  = 1'b0;
                            n_blank = 1'b1;
                            n_drq   = 1'b1;
                        end
                        fin = 1'b1;
                    end
                endcase
            end

            S_RDATA: begin
                rv  = r_blank ? BLANK_BYTE : mem_rdata;
                fin = 1'b1;
            end

            S_IDWRITE: begin
                // write the ID field one byte a cycle
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idcnt);
                case (r_idcnt)
                    3'd0:    mem_wdata = r_track;
                    3'd2:    mem_wdata = r_sector;
                    3'd3:    mem_wdata = ID_SIZE_CODE;
                    default: mem_wdata = '0;
                endcase
                n_idcnt = r_idcnt + 3'd1;
                if (r_idcnt == 3'(ID_BYTES - 1)) begin
                    fin = 1'b1;
                end
            end

            S_OFFSET: begin
                if (off_rsp.done) begin
                    fstart = 1'b1;
                    foff   = off_rsp.offset;
                    fin    = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Present the result transaction
        if (fin) begin
            n_done                  = 1'b1;
            n_result.read_value     = rv;
            n_result.interrupt_line = n_intrq;
            n_result.data_request   = n_drq;
            n_result.fetch_start    = fstart;
            n_result.fetch_offset   = foff;
            n_state                 = S_IDLE;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_result <= n_result;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= '0;
            r_command <= '0;
            r_track   <= '0;
            r_sector  <= '0;
            r_data    <= '0;
            r_drq     <= 1'b0;
            r_intrq   <= 1'b0;
            r_ipulse  <= 1'b0;
            r_icnt    <= '0;
            r_rptr    <= '0;
            r_tl      <= '0;
            r_fptr    <= '0;
            r_fill    <= 1'b0;
            r_blank   <= 1'b0;
            r_idcnt   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_command <= n_command;
            r_track   <= n_track;
            r_sector  <= n_sector;
            r_data    <= n_data;
            r_drq     <= n_drq;
            r_intrq   <= n_intrq;
            r_ipulse  <= n_ipulse;
            r_icnt    <= n_icnt;
            r_rptr    <= n_rptr;
            r_tl      <= n_tl;
            r_fptr    <= n_fptr;
            r_fill    <= n_fill;
            r_blank   <= n_blank;
            r_idcnt   <= n_idcnt;
            r_done    <= n_done;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- rtl/core/fdc_checker.sv -----
// ----------------------------------------------------------------------------
// Floppy disk controller core - port checker
// Checks the start/busy/done sequencing and the fetch fields of results.
// ----------------------------------------------------------------------------
module fdc_checker
    import fdc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_done,
    input t_fdc_out o_result
);

    // An accepted transaction keeps the core busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("core not busy after an accepted transaction");

    // A result ends the transaction: the core is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a transaction in progress");

    // No fetch, no offset
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.fetch_start |-> o_result.fetch_offset == '0)
        else $error("offset given without a fetch request");

    // A fetch request always leaves the interrupt clear
    a_fetch_intrq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.fetch_start |-> !o_result.interrupt_line)
        else $error("interrupt set on a fetch request");

endmodule

bind floppy_disk_controller_core_unit fdc_checker u_fdc_checker (.*);

// ----- tb/fdc_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Floppy disk controller core - result checker
// Watches the request, result and configuration ports of the core, keeps its
// own copy of the controller registers, flags and sector buffer, works out
// the result of every accepted transaction and compares it field by field
// with the result that the core returns.
// ----------------------------------------------------------------------------
module fdc_core_checker
    import fdc_pkg::*;
#(
    parameter int MAX_SECTOR_BYTES   = DEF_MAX_SECTOR_BYTES,
    parameter int INDEX_TOGGLE_READS = DEF_INDEX_TOGGLE_READS,
    parameter int MAX_REPORTS        = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_fdc_in              i_req,
    input  logic                 i_done,
    input  t_fdc_out             i_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   o_error_count,
    output int                   o_pending
);

    // Configuration copy
    logic [SS_W-1:0]  cfg_ss;
    logic [SPT_W-1:0] cfg_spt;
    logic [TC_W-1:0]  cfg_tracks;
    logic             cfg_image;
    logic             cfg_selected;

    // Controller registers and flags
    logic [BYTE_W-1:0] status_q, command_q, track_q, sector_q, data_q;
    logic              drq, intrq, index_level, filling, blank;
    int                index_reads, rd_ptr, xfer_len, fill_ptr;
    logic [BYTE_W-1:0] sec_bytes [MAX_SECTOR_BYTES];

    t_fdc_out awaited_results [$];
    int       error_count  = 0;
    int       result_count = 0;

    assign o_error_count = error_count;

    // Print one line per mismatch (up to a cap) and count it
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Apply one transaction to the register copy and return its result
    function automatic t_fdc_out step_controller(input t_fdc_in req);
        t_fdc_out          res;
        logic [BYTE_W-1:0] v;
        int                rem;
        int                off;
        res = '0;
        v   = '0;
        case (req.op)
            OP_READ: begin
                case (req.reg_select)
                    REG_CMD: begin
                        // Status: not ready, then track 0 and index or DRQ
                        v = status_q;
                        if (!cfg_image || !cfg_selected)
                            v = v | ST_NOT_READY;
                        if (!command_q[7]) begin
                            if (track_q == '0)
                                v = v | ST_TRACK0;
                            index_reads++;
                            if (index_reads > INDEX_TOGGLE_READS) begin
                                index_level = !index_level;
                                index_reads = 0;
                            end
                            if (index_level)
                                v = v | ST_INDEX;
                        end else if (drq) begin
                            v = v | ST_DRQ;
                        end
                        intrq = 1'b0;
                    end
                    REG_TRACK:  v = track_q;
                    REG_SECTOR: v = sector_q;
                    default: begin
                        // Drain the buffer while DRQ holds, else return data_q
                        if (drq && rd_ptr < xfer_len) begin
                            if (blank)
                                v = BLANK_BYTE;
                            else if (rd_ptr < MAX_SECTOR_BYTES)
                                v = sec_bytes[rd_ptr];
                            else
                                v = '0;
                            rd_ptr++;
                            if (rd_ptr >= xfer_len) begin
                                drq      = 1'b0;
                                intrq    = 1'b1;
                                status_q = '0;
                            end
                        end else begin
                            v = data_q;
                        end
                    end
                endcase
                res.read_value = v;
            end
            OP_WRITE: begin
                case (req.reg_select)
                    REG_CMD: begin
                        command_q = req.write_value;
                        filling   = 1'b0;
                        if (!command_q[7]) begin
                            // Type I: restore, seek or other stepping command
                            if ((command_q & CMD_TYPE_MASK) == CMD_RESTORE) begin
                                track_q  = '0;
                                status_q = ST_TRACK0;
                            end else if ((command_q & CMD_TYPE_MASK) == CMD_SEEK) begin
                                track_q  = data_q;
                                status_q = '0;
                            end
                            intrq = 1'b1;
                        end else if ((command_q & CMD_READ_MASK) == CMD_READ_SECTOR) begin
                            status_q = ST_BUSY;
                            intrq    = 1'b0;
                            rd_ptr   = 0;
                            xfer_len = (cfg_ss > MAX_SECTOR_BYTES) ? MAX_SECTOR_BYTES
                                                                   : int'(cfg_ss);
                            if (cfg_image && track_q < cfg_tracks) begin
                                rem = (cfg_spt != '0) ? int'(sector_q) % int'(cfg_spt) : 0;
                                off = (int'(track_q) * int'(cfg_spt) + rem) * int'(cfg_ss);
                                res.fetch_start  = 1'b1;
                                res.fetch_offset = off[OFFSET_W-1:0];
                                blank    = 1'b0;
                                fill_ptr = 0;
                                if (xfer_len == 0) begin
                                    drq = 1'b1;
                                end else begin
                                    filling = 1'b1;
                                    drq     = 1'b0;
                                end
                            end else begin
                                blank = 1'b1;
                                drq   = 1'b1;
                            end
                        end else if ((command_q & CMD_TYPE_MASK) == CMD_READ_ADDR) begin
                            // Load the six ID field bytes
                            status_q     = ST_BUSY;
                            intrq        = 1'b0;
                            rd_ptr       = 0;
                            xfer_len     = ID_BYTES;
                            sec_bytes[0] = track_q;
                            sec_bytes[1] = '0;
                            sec_bytes[2] = sector_q;
                            sec_bytes[3] = ID_SIZE_CODE;
                            sec_bytes[4] = '0;
                            sec_bytes[5] = '0;
                            blank        = 1'b0;
                            drq          = 1'b1;
                        end else if ((command_q & CMD_TYPE_MASK) == CMD_FORCE_INT) begin
                            status_q = '0;
                            intrq    = (command_q[3:0] != '0);
                        end else begin
                            status_q = '0;
                            intrq    = 1'b1;
                        end
                    end
                    REG_TRACK:  track_q  = req.write_value;
                    REG_SECTOR: sector_q = req.write_value;
                    default:    data_q   = req.write_value;
                endcase
            end
            OP_BYTE: begin
                // Store the byte; raise DRQ once the sector is complete
                if (filling) begin
                    if (fill_ptr < MAX_SECTOR_BYTES)
                        sec_bytes[fill_ptr] = req.disk_byte;
                    fill_ptr++;
                    if (fill_ptr >= xfer_len) begin
                        filling = 1'b0;
                        drq     = 1'b1;
                    end
                end
            end
            default: begin
                if (filling) begin
                    filling = 1'b0;
                    blank   = 1'b1;
                    drq     = 1'b1;
                end
            end
        endcase
        res.interrupt_line = intrq;
        res.data_request   = drq;
        return res;
    endfunction

    // Track configuration, check results, predict on acceptance
    always @(posedge i_clk) begin : monitor
        t_fdc_out want;
        if (!i_rst_n) begin
            cfg_ss       = RST_SECTOR_SIZE;
            cfg_spt      = RST_SPT;
            cfg_tracks   = RST_TRACK_COUNT;
            cfg_image    = 1'b0;
            cfg_selected = 1'b0;
            status_q     = '0;
            command_q    = '0;
            track_q      = '0;
            sector_q     = '0;
            data_q       = '0;
            drq          = 1'b0;
            intrq        = 1'b0;
            index_level  = 1'b0;
            filling      = 1'b0;
            blank        = 1'b0;
            index_reads  = 0;
            rd_ptr       = 0;
            xfer_len     = 0;
            fill_ptr     = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SECTOR_SIZE:   cfg_ss       = i_cfg_wdata[SS_W-1:0];
                    CFG_SECTORS_PER_T: cfg_spt      = i_cfg_wdata[SPT_W-1:0];
                    CFG_TRACK_COUNT:   cfg_tracks   = i_cfg_wdata[TC_W-1:0];
                    CFG_IMAGE_PRESENT: cfg_image    = i_cfg_wdata[0];
                    CFG_DRIVE_SELECT:  cfg_selected = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_done) begin
                result_count++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing awaited",
                                              result_count));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result.read_value !== want.read_value)
                        report_mismatch($sformatf("result %0d read_value 0x%0h, expected 0x%0h",
                            result_count, i_result.read_value, want.read_value));
                    if (i_result.interrupt_line !== want.interrupt_line)
                        report_mismatch($sformatf("result %0d interrupt_line %b, expected %b",
                            result_count, i_result.interrupt_line, want.interrupt_line));
                    if (i_result.data_request !== want.data_request)
                        report_mismatch($sformatf("result %0d data_request %b, expected %b",
                            result_count, i_result.data_request, want.data_request));
                    if (i_result.fetch_start !== want.fetch_start)
                        report_mismatch($sformatf("result %0d fetch_start %b, expected %b",
                            result_count, i_result.fetch_start, want.fetch_start));
                    if (i_result.fetch_offset !== want.fetch_offset)
                        report_mismatch($sformatf("result %0d fetch_offset 0x%0h, expected 0x%0h",
                            result_count, i_result.fetch_offset, want.fetch_offset));
                end
            end
            if (i_start && !i_busy)
                awaited_results.push_back(step_controller(i_req));
        end
        o_pending <= awaited_results.size();
    end

endmodule

// ----- tb/floppy_disk_controller_core_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Floppy disk controller core - testbench
// Drives bus reads and writes, store bytes and store failures into the core
// through its start/busy port, with directed corner cases first and then
// random command sequences (sector transfers, ID reads, stepping commands,
// interrupts, register traffic and noise) over a range of configurations
// and sender idle rates. Results are checked by the checker alongside.
// ----------------------------------------------------------------------------
module floppy_disk_controller_core_unit_tb;
    import fdc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int REQ_W           = $bits(t_fdc_in);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    t_fdc_in              i_req       = '0;
    logic                 busy;
    logic                 o_done;
    t_fdc_out             o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    int fail_count;
    int pending;
    int gap_pct     = 0;
    int item_count  = 0;
    int unsigned quiet_cycles = 0;

    // Configuration as last written, masked to register widths
    logic [SS_W-1:0] cur_ss;
    logic [TC_W-1:0] cur_tc;
    logic            cur_img;

    floppy_disk_controller_core_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    fdc_core_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_done        (o_done),
        .i_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_error_count (fail_count),
        .o_pending     (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run when nothing has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one transaction, idling first at the phase rate; hold until taken
    task automatic send_txn(input t_fdc_in txn);
        logic [REQ_W-1:0] noise_bits;
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            noise_bits = REQ_W'($urandom);
            start <= 1'b0;
            i_req <= t_fdc_in'(noise_bits);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= txn;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        item_count++;
    endtask

    // Build a transaction; unused fields carry random bits
    task automatic issue(input t_op op, input logic [1:0] sel, input logic [BYTE_W-1:0] val);
        t_fdc_in txn;
        txn.op          = op;
        txn.reg_select  = sel;
        txn.write_value = (op == OP_WRITE) ? val : BYTE_W'($urandom);
        txn.disk_byte   = (op == OP_BYTE) ? val : BYTE_W'($urandom);
        send_txn(txn);
    endtask

    // Drop start and wait until every result is back
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0 || busy);
    endtask

    // Write all five registers with random bits above each width, then a spare index
    task automatic configure(input logic [SS_W-1:0] ss, input logic [SPT_W-1:0] spt,
                             input logic [TC_W-1:0] tc, input logic img, input logic sel);
        logic [CFG_W-1:0]     junk;
        logic [CFG_IDX_W-1:0] spare_idx;
        junk      = CFG_W'($urandom);
        spare_idx = CFG_IDX_W'($urandom_range(CFG_DRIVE_SELECT + 1, 2**CFG_IDX_W - 1));
        settle();
        cur_ss  = ss;
        cur_tc  = tc;
        cur_img = img;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_SECTOR_SIZE;
        i_cfg_wdata <= ss;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_SECTORS_PER_T;
        i_cfg_wdata <= {junk[CFG_W-1:SPT_W], spt};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_TRACK_COUNT;
        i_cfg_wdata <= {junk[CFG_W-1:TC_W], tc};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_IMAGE_PRESENT;
        i_cfg_wdata <= {junk[CFG_W-1:1], img};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_DRIVE_SELECT;
        i_cfg_wdata <= {junk[CFG_W-2:0], sel};
        @(posedge i_clk);
        i_cfg_idx   <= spare_idx;
        i_cfg_wdata <= ~junk;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Read Sector on a track, feed the store side, then poll and drain
    task automatic sector_transfer(input logic [TRACK_W-1:0] trk, input bit allow_abort);
        int len, cut, pick, n, i;
        bit fetching, ready;
        issue(OP_WRITE, REG_TRACK, trk);
        issue(OP_WRITE, REG_SECTOR, BYTE_W'($urandom_range(0, 255)));
        issue(OP_WRITE, REG_CMD, CMD_READ_SECTOR | BYTE_W'($urandom_range(0, 31)));
        len      = (cur_ss > DEF_MAX_SECTOR_BYTES) ? DEF_MAX_SECTOR_BYTES : int'(cur_ss);
        fetching = cur_img && trk < cur_tc && len != 0;
        ready    = 1'b1;
        if (fetching) begin
            pick = allow_abort ? int'($urandom_range(0, 9)) : 0;
            cut  = (pick < 8) ? len : int'($urandom_range(0, len - 1));
            for (i = 0; i < cut; i++) begin
                if ($urandom_range(0, 15) == 0)
                    issue(OP_READ, REG_CMD, '0);
                issue(OP_BYTE, REG_DATA, BYTE_W'($urandom_range(0, 255)));
            end
            // Fail the fetch, or abandon it with a command
            if (pick == 8) begin
                issue(OP_FAIL, REG_DATA, '0);
            end else if (pick == 9) begin
                issue(OP_WRITE, REG_CMD, CMD_FORCE_INT | BYTE_W'($urandom_range(0, 15)));
                ready = 1'b0;
            end
        end
        issue(OP_READ, REG_CMD, '0);
        n = ready ? len + int'($urandom_range(0, 2)) : int'($urandom_range(1, 2));
        for (i = 0; i < n; i++)
            issue(OP_READ, REG_DATA, '0);
        issue(OP_READ, REG_CMD, '0);
    endtask

    initial begin
        int phase, goal, choice, n, i;
        logic [TRACK_W-1:0] trk;
        logic [SS_W-1:0]    ss;
        logic [SPT_W-1:0]   spt;
        logic [TC_W-1:0]    tc;
        logic [REQ_W-1:0]   noise_bits;

        cur_ss  = RST_SECTOR_SIZE;
        cur_tc  = RST_TRACK_COUNT;
        cur_img = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: register extremes and every command at reset configuration
        issue(OP_READ, REG_CMD, '0);
        issue(OP_WRITE, REG_TRACK, 8'hff);
        issue(OP_WRITE, REG_SECTOR, 8'hff);
        issue(OP_READ, REG_TRACK, '0);
        issue(OP_READ, REG_SECTOR, '0);
        issue(OP_WRITE, REG_DATA, 8'h00);
        issue(OP_WRITE, REG_CMD, CMD_READ_SECTOR);
        issue(OP_READ, REG_CMD, '0);
        issue(OP_READ, REG_DATA, '0);
        issue(OP_WRITE, REG_CMD, CMD_FORCE_INT);
        issue(OP_WRITE, REG_CMD, CMD_FORCE_INT | 8'h0f);
        issue(OP_READ, REG_CMD, '0);
        issue(OP_WRITE, REG_CMD, 8'he0);
        issue(OP_WRITE, REG_CMD, 8'hff);
        issue(OP_WRITE, REG_DATA, 8'hff);
        issue(OP_WRITE, REG_CMD, CMD_SEEK | 8'h0f);
        issue(OP_WRITE, REG_CMD, CMD_RESTORE);
        issue(OP_READ, REG_CMD, '0);
        issue(OP_WRITE, REG_CMD, 8'h7f);
        issue(OP_BYTE, REG_DATA, 8'hff);
        issue(OP_FAIL, REG_DATA, '0);
        issue(OP_WRITE, REG_CMD, CMD_READ_ADDR);
        for (i = 0; i < ID_BYTES; i++)
            issue(OP_READ, REG_DATA, '0);

        // Zero-length sector and zero sectors per track: DRQ with nothing to read
        configure('0, '0, 8'd255, 1'b1, 1'b1);
        issue(OP_WRITE, REG_CMD, CMD_READ_SECTOR);
        issue(OP_READ, REG_DATA, '0);
        issue(OP_READ, REG_CMD, '0);

        // Oversized sector with offset overflow: fetch request, failed fetch, short drain
        configure(11'h7ff, 7'h7f, 8'd255, 1'b1, 1'b1);
        gap_pct = 16;
        issue(OP_WRITE, REG_TRACK, 8'd254);
        issue(OP_WRITE, REG_SECTOR, 8'hff);
        issue(OP_WRITE, REG_CMD, CMD_READ_SECTOR);
        issue(OP_BYTE, REG_DATA, 8'h5a);
        issue(OP_FAIL, REG_DATA, '0);
        issue(OP_READ, REG_CMD, '0);
        for (i = 0; i < 4; i++)
            issue(OP_READ, REG_DATA, '0);
        issue(OP_WRITE, REG_CMD, CMD_FORCE_INT);

        // Random phases over varied configurations and idle rates
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            ss = ($urandom_range(0, 9) == 0) ? 11'd0 : SS_W'($urandom_range(1, 12));
            case ($urandom_range(0, 4))
                0:       spt = 7'd0;
                1:       spt = 7'd1;
                2:       spt = 7'd64;
                3:       spt = 7'd127;
                default: spt = SPT_W'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 4))
                0:       tc = 8'd0;
                1:       tc = 8'd1;
                2:       tc = 8'd255;
                default: tc = TC_W'($urandom_range(1, 255));
            endcase
            configure(ss, spt, tc, $urandom_range(0, 99) < 85, 1'($urandom_range(0, 1)));
            gap_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 68 : 16;
            goal    = item_count + ITEMS_PER_PHASE;
            while (item_count < goal) begin
                choice = $urandom_range(0, 99);
                if (choice < 40) begin
                    if ($urandom_range(0, 9) < 7 && cur_tc != 0)
                        trk = TRACK_W'($urandom_range(0, cur_tc - 1));
                    else
                        trk = TRACK_W'($urandom_range(0, 255));
                    sector_transfer(trk, 1'b1);
                end else if (choice < 52) begin
                    issue(OP_WRITE, REG_CMD, CMD_READ_ADDR | BYTE_W'($urandom_range(0, 15)));
                    issue(OP_READ, REG_CMD, '0);
                    n = ID_BYTES + $urandom_range(0, 2);
                    for (i = 0; i < n; i++)
                        issue(OP_READ, REG_DATA, '0);
                end else if (choice < 68) begin
                    // Stepping command, then poll status; long polls turn the index over
                    issue(OP_WRITE, REG_DATA, BYTE_W'($urandom_range(0, 255)));
                    issue(OP_WRITE, REG_CMD, BYTE_W'($urandom_range(0, 8'h7f)));
                    n = ($urandom_range(0, 9) == 0) ? DEF_INDEX_TOGGLE_READS + 6
                                                    : $urandom_range(1, 4);
                    for (i = 0; i < n; i++)
                        issue(OP_READ, REG_CMD, '0);
                end else if (choice < 78) begin
                    issue(OP_WRITE, REG_CMD, BYTE_W'($urandom_range(CMD_FORCE_INT, 8'hff)));
                    issue(OP_READ, REG_CMD, '0);
                end else if (choice < 90) begin
                    issue(OP_WRITE, 2'($urandom_range(REG_TRACK, REG_DATA)),
                          BYTE_W'($urandom_range(0, 255)));
                    issue(OP_READ, 2'($urandom_range(REG_TRACK, REG_DATA)), '0);
                end else begin
                    n = $urandom_range(1, 4);
                    for (i = 0; i < n; i++) begin
                        noise_bits = REQ_W'($urandom);
                        send_txn(t_fdc_in'(noise_bits));
                    end
                end
            end
        end

        // Wait for the last results, then give the verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/fdc_pkg.sv
rtl/core/fdc_offset_unit.sv
rtl/core/fdc_sector_buf.sv
rtl/core/floppy_disk_controller_core_unit.sv
rtl/core/fdc_checker.sv
tb/fdc_core_checker.sv
tb/floppy_disk_controller_core_unit_tb.sv
